[rtl/lqem_pkg.sv]
`default_nettype none

package lqem_pkg;

   localparam int DATA_W = 32;
   localparam int CAP_W = 8;
   localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

   typedef enum logic [1:0] {
      OP_ENQ  = 2'd0,
      OP_DEQ  = 2'd1,
      OP_MAX  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DROP,
      S_REPLY
   } state_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  out_value;
      status_type                status;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

`default_nettype wire

[rtl/linear_queue_extract_max.sv]
// Linear queue of signed 32-bit values with dequeue and extract-maximum.
// The request channel (req_valid, req_stall, req_data) carries one beat per
// operation: enqueue, dequeue or extract-maximum. Every accepted beat yields
// exactly one response beat on rsp_valid, rsp_stall, rsp_data with the value
// and a status of ok, full or empty. The user must write the capacity
// register via csr_we and csr_wdata only while idle; the block does not check.
// Enqueue, dequeue, an unused op and any operation that fails give their
// response in the cycle after acceptance; with no stall, one beat per cycle.
// Extract-maximum with L entries held reaches its response in steps:
// the row of cells rotates L times to find the maximum, then L more times
// while the chosen entry is dropped, then the response is loaded once the
// response register is free. No request is taken until the block is idle.
// The response register frees the request side: a new beat is taken while an
// earlier response is still being taken in the same cycle; while rsp_stall
// holds a pending response, req_stall is high.
// Reset clears head, tail and the response valid and sets capacity to 128.
// Slot contents are not cleared; entries are read only after being written.
`default_nettype none

module linear_queue_extract_max #(
   parameter int DEPTH = 128
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  lqem_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output lqem_pkg::rsp_type                    rsp_data,
   input  wire                                  csr_we,
   input  wire [lqem_pkg::CAP_W-1:0]            csr_wdata
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = $clog2(DEPTH);
   localparam int CMPW = (CW > lqem_pkg::CAP_W) ? CW : lqem_pkg::CAP_W;

   lqem_pkg::state_type                 state_ff, state_in;
   logic [CW-1:0]                       head_ff, head_in;
   logic [CW-1:0]                       tail_ff, tail_in;
   logic [lqem_pkg::CAP_W-1:0]          cap_ff;
   logic [PW-1:0]                       j_ff, j_in;
   logic [PW-1:0]                       last_ff, last_in;
   logic [PW-1:0]                       ipos_ff, ipos_in;
   logic [PW-1:0]                       best_ff, best_in;
   logic signed [lqem_pkg::DATA_W-1:0]  max_ff, max_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   lqem_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   logic [CW-1:0]                       cnt;
   logic [CW-1:0]                       cnt_m1;
   logic                                full;
   logic                                empty;
   logic                                rsp_free;
   logic                                produce;
   lqem_pkg::rsp_type                   rsp_new;

   lqem_pkg::cell_ctl_type              ctl;
   logic [PW-1:0]                       pos;
   logic signed [lqem_pkg::DATA_W-1:0]  load_data;
   logic signed [lqem_pkg::DATA_W-1:0]  cell_q [DEPTH];
   logic signed [lqem_pkg::DATA_W-1:0]  cell0;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         if (gi < DEPTH - 1) begin : g_mid
            lqem_cell #(.DEPTH(DEPTH), .IDX(gi)) u_cell (
               .clock     (clock),
               .ctl       (ctl),
               .pos       (pos),
               .load_data (load_data),
               .next_data (cell_q[gi+1]),
               .data      (cell_q[gi])
            );
         end else begin : g_end
            lqem_cell #(.DEPTH(DEPTH), .IDX(gi)) u_cell (
               .clock     (clock),
               .ctl       (ctl),
               .pos       (pos),
               .load_data (load_data),
               .next_data (cell_q[gi]),
               .data      (cell_q[gi])
            );
         end
      end
   endgenerate

   assign cell0 = cell_q[0];
   assign cnt = tail_ff - head_ff;
   assign cnt_m1 = cnt - CW'(1);
   assign full = (CMPW'(tail_ff) >= CMPW'(cap_ff)) || (tail_ff >= CW'(DEPTH));
   assign empty = (head_ff >= tail_ff);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      j_in = j_ff;
      last_in = last_ff;
      ipos_in = ipos_ff;
      best_in = best_ff;
      max_in = max_ff;
      req_stall = 1'b1;
      produce = 1'b0;
      rsp_new.out_value = '0;
      rsp_new.status = lqem_pkg::ST_OK;
      ctl.shift = 1'b0;
      ctl.load = 1'b0;
      pos = '0;
      load_data = cell0;

      case (state_ff)
         lqem_pkg::S_IDLE: begin
            req_stall = !rsp_free;
            if (req_valid && rsp_free) begin
               case (req_data.op)
                  lqem_pkg::OP_ENQ: begin
                     produce = 1'b1;
                     if (full) begin
                        rsp_new.status = lqem_pkg::ST_FULL;
                     end else begin
                        ctl.load = 1'b1;
                        pos = cnt[PW-1:0];
                        load_data = req_data.value;
                        tail_in = tail_ff + CW'(1);
                     end
                  end
                  lqem_pkg::OP_DEQ: begin
                     produce = 1'b1;
                     if (empty) begin
                        rsp_new.status = lqem_pkg::ST_EMPTY;
                     end else begin
                        rsp_new.out_value = cell0;
                        ctl.shift = 1'b1;
                        head_in = head_ff + CW'(1);
                     end
                  end
                  lqem_pkg::OP_MAX: begin
                     if (empty) begin
                        produce = 1'b1;
                        rsp_new.status = lqem_pkg::ST_EMPTY;
                     end else begin
                        state_in = lqem_pkg::S_SCAN;
                        j_in = '0;
                        last_in = cnt_m1[PW-1:0];
                        ipos_in = cnt_m1[PW-1:0];
                     end
                  end
                  default: begin
                     produce = 1'b1;
                  end
               endcase
            end
         end
         lqem_pkg::S_SCAN: begin
            ctl.shift = 1'b1;
            ctl.load = 1'b1;
            pos = ipos_ff;
            if ((j_ff == '0) || (cell0 > max_ff)) begin
               max_in = cell0;
               best_in = j_ff;
            end
            if (j_ff == last_ff) begin
               state_in = lqem_pkg::S_DROP;
               j_in = '0;
            end else begin
               j_in = j_ff + PW'(1);
            end
         end
         lqem_pkg::S_DROP: begin
            ctl.shift = 1'b1;
            if (j_ff == best_ff) begin
               ipos_in = ipos_ff - PW'(1);
            end else begin
               ctl.load = 1'b1;
               pos = ipos_ff;
            end
            if (j_ff == last_ff) begin
               state_in = lqem_pkg::S_REPLY;
               tail_in = tail_ff - CW'(1);
            end else begin
               j_in = j_ff + PW'(1);
            end
         end
         lqem_pkg::S_REPLY: begin
            if (rsp_free) begin
               produce = 1'b1;
               rsp_new.out_value = max_ff;
               state_in = lqem_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lqem_pkg::S_IDLE;
         end
      endcase

      rsp_valid_in = produce || (rsp_valid_ff && rsp_stall);
      rsp_data_in = produce ? rsp_new : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lqem_pkg::S_IDLE;
         head_ff <= '0;
         tail_ff <= '0;
         cap_ff <= lqem_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in;
      last_ff <= last_in;
      ipos_ff <= ipos_in;
      best_ff <= best_in;
      max_ff <= max_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("head index passed tail index");

   a_tail_in_range: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= CW'(DEPTH))
      else $error("tail index beyond depth");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != lqem_pkg::S_IDLE) |-> req_stall)
      else $error("request taken during extract-maximum");

   a_reply_issues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lqem_pkg::S_REPLY && rsp_free) |=>
         (rsp_valid_ff && state_ff == lqem_pkg::S_IDLE))
      else $error("extract-maximum response not issued");

endmodule

`default_nettype wire

[rtl/lqem_cell.sv]
`default_nettype none

module lqem_cell #(
   parameter int DEPTH = 128,
   parameter int IDX = 0
) (
   input  wire                                       clock,
   input  lqem_pkg::cell_ctl_type                    ctl,
   input  wire [$clog2(DEPTH)-1:0]                   pos,
   input  wire signed [lqem_pkg::DATA_W-1:0]         load_data,
   input  wire signed [lqem_pkg::DATA_W-1:0]         next_data,
   output logic signed [lqem_pkg::DATA_W-1:0]        data
);

   localparam int PW = $clog2(DEPTH);

   logic signed [lqem_pkg::DATA_W-1:0] data_ff;
   logic signed [lqem_pkg::DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load && (pos == PW'(IDX))) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

[bench/tb_linear_queue_extract_max.sv]
`default_nettype none

module tb_linear_queue_extract_max;
   import lqem_pkg::*;

   localparam int DEPTH = 128;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int REPORT_LIMIT = 10;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_we = 1'b0;
   logic [CAP_W-1:0]  csr_wdata = '0;

   bit                no_idle = 1'b0;
   int                mismatch_count = 0;
   rsp_type           pending_results[$];

   logic signed [DATA_W-1:0] queue_slots [DEPTH];
   int                head_pos = 0;
   int                tail_pos = 0;
   logic [CAP_W-1:0]  capacity_setting = CAP_RESET;

   linear_queue_extract_max #(
      .DEPTH(DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic rsp_type apply_queue_op(input req_type item);
      rsp_type result;
      int      limit;
      int      best;
      int      i;
      result.out_value = '0;
      result.status = ST_OK;
      limit = (capacity_setting < DEPTH) ? int'(capacity_setting) : DEPTH;
      case (item.op)
         OP_ENQ: begin
            if (tail_pos >= limit) begin
               result.status = ST_FULL;
            end else begin
               queue_slots[tail_pos] = item.value;
               tail_pos++;
            end
         end
         OP_DEQ, OP_MAX: begin
            if (head_pos >= tail_pos) begin
               result.status = ST_EMPTY;
            end else if (item.op == OP_DEQ) begin
               result.out_value = queue_slots[head_pos];
               head_pos++;
            end else begin
               best = head_pos;
               for (i = head_pos + 1; i < tail_pos; i++) begin
                  if (queue_slots[i] > queue_slots[best]) begin
                     best = i;
                  end
               end
               result.out_value = queue_slots[best];
               for (i = best; i + 1 < tail_pos; i++) begin
                  queue_slots[i] = queue_slots[i + 1];
               end
               tail_pos--;
            end
         end
         default: begin
         end
      endcase
      return result;
   endfunction

   function automatic logic [DATA_W-1:0] random_value();
      // Small values make ties between entries common.
      if ($urandom_range(3) == 0) begin
         return DATA_W'($signed($urandom_range(7)) - 4);
      end
      return $urandom;
   endfunction

   function automatic op_type random_op(input int enq_pct, input int max_pct,
                                        input int deq_pct);
      int pick;
      pick = $urandom_range(99);
      if (pick < enq_pct) begin
         return OP_ENQ;
      end else if (pick < enq_pct + max_pct) begin
         return OP_MAX;
      end else if (pick < enq_pct + max_pct + deq_pct) begin
         return OP_DEQ;
      end
      return OP_NONE;
   endfunction

   task automatic send_op(input op_type op, input logic [DATA_W-1:0] value);
      req_type item;
      item.op = op;
      item.value = value;
      while (!no_idle && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      pending_results.push_back(apply_queue_op(item));
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      settle_block();
      csr_wdata <= cap;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      capacity_setting = cap;
   endtask

   task automatic run_random(input int count, input int enq_pct, input int max_pct,
                             input int deq_pct);
      repeat (count) begin
         send_op(random_op(enq_pct, max_pct, deq_pct), random_value());
      end
   endtask

   task automatic test_empty_and_unused();
      send_op(OP_DEQ, 32'h1234_5678);
      send_op(OP_MAX, 32'h8765_4321);
      send_op(OP_NONE, 32'hFFFF_FFFF);
   endtask

   task automatic test_extreme_values();
      send_op(OP_ENQ, 32'h7FFF_FFFF);
      send_op(OP_ENQ, 32'h8000_0000);
      send_op(OP_ENQ, 32'h0000_0000);
      send_op(OP_ENQ, 32'hFFFF_FFFF);
      send_op(OP_ENQ, 32'h7FFF_FFFF);
      send_op(OP_ENQ, 32'h0000_0001);
      send_op(OP_MAX, 32'h0);
      send_op(OP_DEQ, 32'h0);
      send_op(OP_MAX, 32'h0);
      send_op(OP_NONE, 32'h5555_AAAA);
      send_op(OP_MAX, 32'h0);
      send_op(OP_MAX, 32'h0);
   endtask

   task automatic test_capacity_cases();
      // With zero capacity every enqueue is refused.
      write_capacity(8'd0);
      send_op(OP_ENQ, 32'h0000_00FF);
      write_capacity(8'd255);
      send_op(OP_ENQ, 32'hDEAD_BEEF);
      send_op(OP_ENQ, 32'h0BAD_F00D);
      // The tail is now above the capacity, so enqueue reports full.
      write_capacity(8'd1);
      send_op(OP_ENQ, 32'h0000_0002);
      send_op(OP_MAX, 32'h0);
      write_capacity(CAP_RESET);
   endtask

   task automatic test_random_mix();
      run_random(500, 50, 40, 6);
   endtask

   task automatic test_random_capacity();
      logic [CAP_W-1:0] cap;
      repeat (6) begin
         case ($urandom_range(4))
            0: cap = 8'd0;
            1: cap = 8'd255;
            2: cap = 8'd1;
            3: cap = (tail_pos > 1) ? CAP_W'($urandom_range(tail_pos - 1)) : 8'd1;
            default: cap = CAP_W'($urandom_range(128, 1));
         endcase
         write_capacity(cap);
         run_random(80, 50, 40, 6);
      end
      write_capacity(CAP_RESET);
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      run_random(150, 50, 40, 6);
      no_idle = 1'b0;
   endtask

   task automatic test_random_drain();
      // Dequeues walk the head to the end, leaving the queue empty and full.
      run_random(320, 45, 15, 35);
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected result beat: value %0d status %0d",
                        rsp_data.out_value, rsp_data.status);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.out_value !== want.out_value || rsp_data.status !== want.status)
            begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("result mismatch: expected value %0d status %0d, got value %0d status %0d",
                           want.out_value, want.status, rsp_data.out_value, rsp_data.status);
               end
            end
         end
      end
      rsp_stall <= !no_idle && ($urandom_range(99) < 24);
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb_linear_queue_extract_max: done, errors");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_unused();
      test_extreme_values();
      test_capacity_cases();
      test_random_mix();
      test_random_capacity();
      test_back_to_back();
      test_random_drain();
      settle_block();
      repeat (300) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_linear_queue_extract_max: done, clean");
      end else begin
         $display("tb_linear_queue_extract_max: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
